>>> rtl/core/drvseq_pkg.sv
// Shared types, constants and helpers for the drive controlword sequencer.
// Used by drvseq_decode, drvseq_step and drive_controlword_sequencer_core.
package drvseq_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int WORD_WIDTH  = 16;
    localparam int HOLD_WIDTH  = 16;

    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNT_WIDTH) - 33'd1;

    // Statusword masks and compare values of the decode table.
    localparam logic [WORD_WIDTH-1:0] SW_MASK_A      = 16'h004F;
    localparam logic [WORD_WIDTH-1:0] SW_MASK_B      = 16'h006F;
    localparam logic [WORD_WIDTH-1:0] SW_NOT_READY   = 16'h0000;
    localparam logic [WORD_WIDTH-1:0] SW_SWON_DIS    = 16'h0040;
    localparam logic [WORD_WIDTH-1:0] SW_READY       = 16'h0021;
    localparam logic [WORD_WIDTH-1:0] SW_SWITCHED_ON = 16'h0023;
    localparam logic [WORD_WIDTH-1:0] SW_OP_ENABLED  = 16'h0027;
    localparam logic [WORD_WIDTH-1:0] SW_QUICK_STOP  = 16'h0007;
    localparam logic [WORD_WIDTH-1:0] SW_FAULT_REACT = 16'h000F;
    localparam logic [WORD_WIDTH-1:0] SW_FAULT       = 16'h0008;

    // Controlwords.
    localparam logic [WORD_WIDTH-1:0] CW_DISABLE  = 16'h0000;
    localparam logic [WORD_WIDTH-1:0] CW_QSTOP    = 16'h0002;
    localparam logic [WORD_WIDTH-1:0] CW_SHUTDOWN = 16'h0006;
    localparam logic [WORD_WIDTH-1:0] CW_SWON     = 16'h0007;
    localparam logic [WORD_WIDTH-1:0] CW_ENOP     = 16'h000F;
    localparam logic [WORD_WIDTH-1:0] CW_FRESET   = 16'h0080;
    localparam int                    CW_FRESET_BIT = 7;

    typedef enum logic [2:0] {
        TGT_IDLE         = 3'd0,
        TGT_DISABLE_VOLT = 3'd1,
        TGT_QUICK_STOP   = 3'd2,
        TGT_SHUTDOWN     = 3'd3,
        TGT_SWITCH_ON    = 3'd4,
        TGT_DISABLE_OP   = 3'd5,
        TGT_ENABLE_OP    = 3'd6,
        TGT_UNDEFINED    = 3'd7
    } t_target;

    typedef enum logic [3:0] {
        ST_NOT_READY   = 4'd0,
        ST_SWON_DIS    = 4'd1,
        ST_READY       = 4'd2,
        ST_SWITCHED_ON = 4'd3,
        ST_OP_ENABLED  = 4'd4,
        ST_QUICK_STOP  = 4'd5,
        ST_FAULT_REACT = 4'd6,
        ST_FAULT       = 4'd7,
        ST_UNKNOWN     = 4'd8
    } t_drive_state;

    // Configuration register indexes.
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_HOLD   = 1'b1;

    // Per-item request from the top level to the step logic.
    typedef struct packed {
        logic                  accept;
        logic                  pulse_start;
        t_target               target;
        logic [HOLD_WIDTH-1:0] hold_cfg;
    } t_step_req;

    // A hold of zero counts as one; the result is clamped to the counter range.
    function automatic logic [COUNT_WIDTH-1:0] clamp_hold(input logic [HOLD_WIDTH-1:0] h);
        logic [32:0] ext;
        ext = (h == '0) ? 33'd1 : 33'(h);
        if (ext > CNT_MAX_W) begin
            return CNT_MAX_W[COUNT_WIDTH-1:0];
        end
        return COUNT_WIDTH'(ext);
    endfunction

endpackage

>>> rtl/core/drive_controlword_sequencer_core.sv
// Each accepted item's result is written into the output register.
// Throughput: one item per clock; the output register frees itself when taken,
// so input stall is raised only while a held result is stalled downstream.
// Reset (synchronous, active low): target idle, hold one, no pulse, held word
// zero, output empty. Depends on drvseq_pkg, drvseq_decode and drvseq_step.
module drive_controlword_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [drvseq_pkg::HOLD_WIDTH-1:0]   i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [drvseq_pkg::WORD_WIDTH-1:0]   i_statusword,
    input  logic                                i_fault_clear_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [drvseq_pkg::WORD_WIDTH-1:0]   o_controlword,
    output logic [3:0]                          o_drive_state,
    output logic                                o_goal_reached
);
    import drvseq_pkg::*;

    t_target               r_target;
    logic [HOLD_WIDTH-1:0] r_hold_cfg;

    logic                  r_out_valid;
    logic [WORD_WIDTH-1:0] r_controlword;
    t_drive_state          r_drive_state;
    logic                  r_goal_reached;

    logic                  in_accept;
    t_step_req             step_req;
    t_drive_state          dec_state;
    logic                  dec_reached;
    logic [WORD_WIDTH-1:0] step_word;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign step_req.accept      = in_accept;
    assign step_req.pulse_start = in_accept && i_fault_clear_req;
    assign step_req.target      = r_target;
    assign step_req.hold_cfg    = r_hold_cfg;

    drvseq_decode u_decode (
        .i_statusword   (i_statusword),
        .i_target       (r_target),
        .o_drive_state  (dec_state),
        .o_goal_reached (dec_reached)
    );

    drvseq_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (step_req),
        .i_drive_state (dec_state),
        .o_controlword (step_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TGT_IDLE;
            r_hold_cfg <= HOLD_WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET: r_target   <= t_target'(i_cfg_wdata[2:0]);
                CFG_HOLD:   r_hold_cfg <= i_cfg_wdata;
                default:    r_hold_cfg <= r_hold_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_controlword  <= step_word;
            r_drive_state  <= dec_state;
            r_goal_reached <= dec_reached;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_controlword  = r_controlword;
    assign o_drive_state  = r_drive_state;
    assign o_goal_reached = r_goal_reached;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output register is free");

    a_request_gives_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_fault_clear_req) |=>
            (o_out_valid && o_controlword == CW_DISABLE))
        else $error("fault-reset request did not start with a low controlword");

    a_idle_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_target == TGT_IDLE) |=> o_goal_reached)
        else $error("idle target not reported as reached");
`endif

endmodule

>>> rtl/core/drvseq_decode.sv
// Statusword decode and target check for the drive controlword sequencer.
// Depends on drvseq_pkg.
module drvseq_decode (
    input  logic [drvseq_pkg::WORD_WIDTH-1:0] i_statusword,
    input  drvseq_pkg::t_target               i_target,
    output drvseq_pkg::t_drive_state          o_drive_state,
    output logic                              o_goal_reached
);
    import drvseq_pkg::*;

    logic [WORD_WIDTH-1:0] sw_a;
    logic [WORD_WIDTH-1:0] sw_b;

    assign sw_a = i_statusword & SW_MASK_A;
    assign sw_b = i_statusword & SW_MASK_B;

    // Rows are tried in order; the first match wins.
    always_comb begin
        if (sw_a == SW_NOT_READY) begin
            o_drive_state = ST_NOT_READY;
        end else if (sw_a == SW_SWON_DIS) begin
            o_drive_state = ST_SWON_DIS;
        end else if (sw_b == SW_READY) begin
            o_drive_state = ST_READY;
        end else if (sw_b == SW_SWITCHED_ON) begin
            o_drive_state = ST_SWITCHED_ON;
        end else if (sw_b == SW_OP_ENABLED) begin
            o_drive_state = ST_OP_ENABLED;
        end else if (sw_b == SW_QUICK_STOP) begin
            o_drive_state = ST_QUICK_STOP;
        end else if (sw_a == SW_FAULT_REACT) begin
            o_drive_state = ST_FAULT_REACT;
        end else if (sw_a == SW_FAULT) begin
            o_drive_state = ST_FAULT;
        end else begin
            o_drive_state = ST_UNKNOWN;
        end
    end

    always_comb begin
        case (i_target)
            TGT_IDLE:         o_goal_reached = 1'b1;
            TGT_DISABLE_VOLT: o_goal_reached = (o_drive_state == ST_SWON_DIS);
            TGT_QUICK_STOP:   o_goal_reached = (o_drive_state == ST_QUICK_STOP);
            TGT_SHUTDOWN:     o_goal_reached = (o_drive_state == ST_READY);
            TGT_SWITCH_ON,
            TGT_DISABLE_OP:   o_goal_reached = (o_drive_state == ST_SWITCHED_ON);
            TGT_ENABLE_OP:    o_goal_reached = (o_drive_state == ST_OP_ENABLED);
            default:          o_goal_reached = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/drvseq_step.sv
// Fault-reset pulse sequencer and controlword selection.
// Holds the pulse state and the last word sent, with its fault-reset bit clear. Depends on drvseq_pkg.
module drvseq_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  drvseq_pkg::t_step_req             i_req,
    input  drvseq_pkg::t_drive_state          i_drive_state,
    output logic [drvseq_pkg::WORD_WIDTH-1:0] o_controlword
);
    import drvseq_pkg::*;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] r_hold;
    logic [COUNT_WIDTH-1:0] n_hold;
    logic [WORD_WIDTH-1:0]  r_held_word;
    logic [WORD_WIDTH-1:0]  n_held_word;

    t_phase                 phase_eff;
    logic [COUNT_WIDTH-1:0] count_eff;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [WORD_WIDTH-1:0]  goal_word;

    // A new request restarts the pulse before this item is handled.
    assign phase_eff = i_req.pulse_start ? PH_LOW : r_phase;
    assign count_eff = i_req.pulse_start ? '0 : r_count;
    assign n_hold    = i_req.pulse_start ? clamp_hold(i_req.hold_cfg) : r_hold;
    assign count_inc = count_eff + COUNT_WIDTH'(1);

    always_comb begin
        goal_word = r_held_word;
        case (i_req.target)
            TGT_DISABLE_VOLT: goal_word = CW_DISABLE;
            TGT_QUICK_STOP:   goal_word = CW_QSTOP;
            TGT_SHUTDOWN:     goal_word = CW_SHUTDOWN;
            TGT_SWITCH_ON,
            TGT_DISABLE_OP: begin
                goal_word = (i_drive_state == ST_SWON_DIS) ? CW_SHUTDOWN : CW_SWON;
            end
            TGT_ENABLE_OP: begin
                if (i_drive_state == ST_SWON_DIS) begin
                    goal_word = CW_SHUTDOWN;
                end else if (i_drive_state == ST_READY) begin
                    goal_word = CW_SWON;
                end else if (i_drive_state == ST_SWITCHED_ON ||
                             i_drive_state == ST_OP_ENABLED) begin
                    goal_word = CW_ENOP;
                end else begin
                    goal_word = CW_DISABLE;
                end
            end
            default: goal_word = r_held_word;
        endcase
        goal_word[CW_FRESET_BIT] = 1'b0;
    end

    always_comb begin
        case (phase_eff)
            PH_LOW: begin
                o_controlword = CW_DISABLE;
                n_phase       = PH_HIGH;
                n_count       = '0;
                n_held_word   = CW_DISABLE;
            end
            PH_HIGH: begin
                o_controlword = CW_DISABLE | CW_FRESET;
                n_held_word   = CW_DISABLE;
                if (count_inc >= n_hold) begin
                    n_phase = PH_NONE;
                    n_count = '0;
                end else begin
                    n_phase = PH_HIGH;
                    n_count = count_inc;
                end
            end
            default: begin
                o_controlword = goal_word;
                n_phase       = PH_NONE;
                n_count       = '0;
                n_held_word   = goal_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NONE;
            r_count     <= '0;
            r_hold      <= COUNT_WIDTH'(1);
            r_held_word <= CW_DISABLE;
        end else if (i_req.accept) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_hold      <= n_hold;
            r_held_word <= n_held_word;
        end
    end

`ifndef SYNTHESIS
    a_held_no_freset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_word[CW_FRESET_BIT])
        else $error("held word carries the fault-reset bit");

    a_count_below_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HIGH) |-> (r_count < r_hold) && (r_hold != '0))
        else $error("pulse counter reached hold while still high");

    a_low_then_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.accept && phase_eff == PH_LOW) |=> (r_phase == PH_HIGH) && (r_count == '0))
        else $error("low pulse cycle not followed by high phase");
`endif

endmodule

>>> tb/tb_drive_controlword_sequencer_core.sv
// Self-checking testbench for drive_controlword_sequencer_core: statusword decode,
// controlword stepping toward the target, fault-reset pulses and output back-pressure.
// Depends on drvseq_pkg and the core RTL; needs no files or arguments.
module tb_drive_controlword_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import drvseq_pkg::*;

    localparam int IDLE_LIMIT     = 3000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int RANDOM_PHASES  = 18;
    localparam int PHASE_ITEMS    = 40;
    // Matches neither row set of the decode table.
    localparam logic [WORD_WIDTH-1:0] SW_NO_MATCH = 16'h004F;
    // Bits that no decode mask looks at.
    localparam logic [WORD_WIDTH-1:0] SW_DONT_CARE = 16'hFF90;

    typedef enum logic [1:0] {
        PULSE_NONE = 2'd0,
        PULSE_LOW  = 2'd1,
        PULSE_HIGH = 2'd2
    } t_pulse_phase;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] controlword;
        t_drive_state          state;
        logic                  reached;
    } t_ctrl_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = 1'b0;
    logic [HOLD_WIDTH-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [WORD_WIDTH-1:0] i_statusword = '0;
    logic                  i_fault_clear_req = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [WORD_WIDTH-1:0] o_controlword;
    logic [3:0]            o_drive_state;
    logic                  o_goal_reached;

    // Predictor copy of the configuration and the sequencer state.
    t_target               cfg_target = TGT_IDLE;
    logic [HOLD_WIDTH-1:0] cfg_hold = 16'd1;
    t_pulse_phase          fr_phase = PULSE_NONE;
    logic [COUNT_WIDTH-1:0] fr_count = '0;
    logic [COUNT_WIDTH-1:0] fr_hold = 16'd1;
    logic [WORD_WIDTH-1:0] last_word = '0;

    t_ctrl_result expected_words[$];

    int  items_sent = 0;
    int  results_checked = 0;
    int  error_count = 0;
    int  pulses_started = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    bit  holdoff_req = 1'b0;
    int  holdoff_left = 0;

    drive_controlword_sequencer_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_statusword      (i_statusword),
        .i_fault_clear_req (i_fault_clear_req),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_controlword     (o_controlword),
        .o_drive_state     (o_drive_state),
        .o_goal_reached    (o_goal_reached)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_drive_state decode_status(input logic [WORD_WIDTH-1:0] sw);
        if ((sw & SW_MASK_A) == SW_NOT_READY)   return ST_NOT_READY;
        if ((sw & SW_MASK_A) == SW_SWON_DIS)    return ST_SWON_DIS;
        if ((sw & SW_MASK_B) == SW_READY)       return ST_READY;
        if ((sw & SW_MASK_B) == SW_SWITCHED_ON) return ST_SWITCHED_ON;
        if ((sw & SW_MASK_B) == SW_OP_ENABLED)  return ST_OP_ENABLED;
        if ((sw & SW_MASK_B) == SW_QUICK_STOP)  return ST_QUICK_STOP;
        if ((sw & SW_MASK_A) == SW_FAULT_REACT) return ST_FAULT_REACT;
        if ((sw & SW_MASK_A) == SW_FAULT)       return ST_FAULT;
        return ST_UNKNOWN;
    endfunction

    function automatic logic target_met(input t_drive_state st);
        case (cfg_target)
            TGT_IDLE:         return 1'b1;
            TGT_DISABLE_VOLT: return st == ST_SWON_DIS;
            TGT_QUICK_STOP:   return st == ST_QUICK_STOP;
            TGT_SHUTDOWN:     return st == ST_READY;
            TGT_SWITCH_ON,
            TGT_DISABLE_OP:   return st == ST_SWITCHED_ON;
            TGT_ENABLE_OP:    return st == ST_OP_ENABLED;
            default:          return 1'b0;
        endcase
    endfunction

    // Advances the predicted sequencer by one item and returns the controlword, drive state and reached flag.
    function automatic t_ctrl_result step_sequencer(input logic [WORD_WIDTH-1:0] sw,
                                                   input logic frr);
        t_ctrl_result r;
        t_drive_state st;
        logic [WORD_WIDTH-1:0] cw;
        if (frr) begin
            fr_hold  = (cfg_hold == '0) ? 16'd1 : cfg_hold;
            fr_phase = PULSE_LOW;
            fr_count = '0;
        end
        st = decode_status(sw);
        case (fr_phase)
            PULSE_LOW: begin
                cw = CW_DISABLE;
                fr_phase = PULSE_HIGH;
                fr_count = '0;
                last_word = CW_DISABLE;
            end
            PULSE_HIGH: begin
                cw = CW_DISABLE | CW_FRESET;
                fr_count = fr_count + 1'b1;
                if (fr_count >= fr_hold) begin
                    fr_phase = PULSE_NONE;
                    fr_count = '0;
                end
                last_word = CW_DISABLE;
            end
            default: begin
                cw = last_word;
                case (cfg_target)
                    TGT_DISABLE_VOLT: cw = CW_DISABLE;
                    TGT_QUICK_STOP:   cw = CW_QSTOP;
                    TGT_SHUTDOWN:     cw = CW_SHUTDOWN;
                    TGT_SWITCH_ON,
                    TGT_DISABLE_OP:   cw = (st == ST_SWON_DIS) ? CW_SHUTDOWN : CW_SWON;
                    TGT_ENABLE_OP: begin
                        if (st == ST_SWON_DIS)
                            cw = CW_SHUTDOWN;
                        else if (st == ST_READY)
                            cw = CW_SWON;
                        else if (st == ST_SWITCHED_ON || st == ST_OP_ENABLED)
                            cw = CW_ENOP;
                        else
                            cw = CW_DISABLE;
                    end
                    default: ;
                endcase
                cw[CW_FRESET_BIT] = 1'b0;
                last_word = cw;
            end
        endcase
        r.controlword = cw;
        r.state = st;
        r.reached = target_met(st);
        return r;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] canonical_status(input int k);
        case (k)
            0:       return SW_NOT_READY;
            1:       return SW_SWON_DIS;
            2:       return SW_READY;
            3:       return SW_SWITCHED_ON;
            4:       return SW_OP_ENABLED;
            5:       return SW_QUICK_STOP;
            6:       return SW_FAULT_REACT;
            7:       return SW_FAULT;
            default: return SW_NO_MATCH;
        endcase
    endfunction

    // Mostly a valid drive state with random don't-care bits, sometimes pure noise.
    function automatic logic [WORD_WIDTH-1:0] random_status();
        if ($urandom_range(0, 99) < 25)
            return WORD_WIDTH'($urandom);
        return canonical_status($urandom_range(0, 8)) | (WORD_WIDTH'($urandom) & SW_DONT_CARE);
    endfunction

    task automatic send_status(input logic [WORD_WIDTH-1:0] sw, input logic frr);
        int gap;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_statusword <= sw;
        i_fault_clear_req <= frr;
        do @(posedge i_clk); while (o_in_stall);
        expected_words.push_back(step_sequencer(sw, frr));
        items_sent++;
        if (frr)
            pulses_started++;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [HOLD_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_TARGET)
            cfg_target = t_target'(data[2:0]);
        else
            cfg_hold = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_decode_table();
        for (int k = 0; k < 9; k++)
            send_status(canonical_status(k) | ((k % 2) ? 16'hFF80 : 16'h0000), 1'b0);
        send_status(16'hFFFF, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_target_steps();
        write_reg(CFG_TARGET, 16'(TGT_ENABLE_OP));
        send_status(SW_SWON_DIS, 1'b0);
        send_status(SW_READY, 1'b0);
        send_status(SW_SWITCHED_ON, 1'b0);
        send_status(SW_OP_ENABLED, 1'b0);
        wait_for_drain();
        // The undefined target repeats the last word and never reports reached.
        write_reg(CFG_TARGET, 16'(TGT_UNDEFINED));
        send_status(SW_OP_ENABLED, 1'b0);
        wait_for_drain();
        write_reg(CFG_TARGET, 16'(TGT_ENABLE_OP));
        send_status(SW_FAULT, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_fault_reset_pulse();
        write_reg(CFG_HOLD, 16'd0);
        send_status(SW_FAULT, 1'b1);
        send_status(SW_FAULT, 1'b0);
        send_status(SW_READY, 1'b0);
        wait_for_drain();
        // A second request in the high phase restarts from the low cycle.
        write_reg(CFG_HOLD, 16'd3);
        send_status(SW_FAULT, 1'b1);
        send_status(SW_FAULT, 1'b0);
        send_status(SW_FAULT, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_long_reset_hold();
        write_reg(CFG_HOLD, 16'hFFFF);
        send_status(SW_FAULT, 1'b1);
        send_status(SW_SWITCHED_ON, 1'b0);
        send_status(SW_OP_ENABLED, 1'b0);
        wait_for_drain();
        write_reg(CFG_HOLD, 16'd1);
        send_status(SW_READY, 1'b1);
        send_status(SW_READY, 1'b0);
        send_status(SW_READY, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idle = (p < 3);
            write_reg(CFG_TARGET, 16'($urandom_range(0, 7)));
            if ($urandom_range(0, 1))
                write_reg(CFG_HOLD, ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5))
                                                               : 16'($urandom_range(6, 40)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_status(random_status(), $urandom_range(0, 99) < 6);
            wait_for_drain();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_holdoff();
        write_reg(CFG_TARGET, 16'(TGT_SWITCH_ON));
        write_reg(CFG_HOLD, 16'd2);
        holdoff_req = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_status(random_status(), $urandom_range(0, 99) < 6);
        wait_for_drain();
    endtask

    // Result side: random stalls, a quiet stretch, and one long hold-off on request.
    always @(negedge i_clk) begin
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < 14);
        end
    end

    always @(posedge i_clk) begin
        t_ctrl_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result cw=%h state=%0d reached=%b", $realtime,
                         o_controlword, o_drive_state, o_goal_reached);
                error_count++;
            end else begin
                exp_r = expected_words.pop_front();
                results_checked++;
                if (o_controlword !== exp_r.controlword) begin
                    $display("%0t: controlword expected %h actual %h", $realtime,
                             exp_r.controlword, o_controlword);
                    error_count++;
                end
                if (o_drive_state !== exp_r.state) begin
                    $display("%0t: drive_state expected %0d actual %0d", $realtime,
                             exp_r.state, o_drive_state);
                    error_count++;
                end
                if (o_goal_reached !== exp_r.reached) begin
                    $display("%0t: goal_reached expected %b actual %b", $realtime,
                             exp_r.reached, o_goal_reached);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding", $realtime,
                     idle_cycles, expected_words.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_decode_table();
        test_target_steps();
        test_fault_reset_pulse();
        test_long_reset_hold();
        test_random_traffic();
        test_output_holdoff();
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d controlwords from %0d statuswords, %0d fault-reset requests,",
                 results_checked, items_sent, pulses_started);
        $display("all targets incl. undefined, hold extremes and a %0d-cycle output hold-off.",
                 HOLDOFF_CYCLES);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     expected_words.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/drvseq_pkg.sv
rtl/core/drvseq_decode.sv
rtl/core/drvseq_step.sv
rtl/core/drive_controlword_sequencer_core.sv
tb/tb_drive_controlword_sequencer_core.sv
